[src/alpha_composite_over_checker_core_macros.svh]
// Assertion macros shared by the compositor RTL.
`ifndef ALPHA_COMPOSITE_OVER_CHECKER_CORE_MACROS_SVH
`define ALPHA_COMPOSITE_OVER_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and idle during reset.
`define ACOC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("Assertion failed in compositor pipeline.");

// Next-cycle implication, sampled on the rising clock edge and idle during reset.
`define ACOC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("Assertion failed in compositor pipeline.");

`endif

[src/acoc_pkg.sv]
package acoc_pkg;

   localparam int COORD_W = 12;
   localparam int CHAN_W = 8;
   localparam int CSR_IDX_W = 3;

   localparam int CELL_SIZE = 10;
   // Reciprocal of the cell size scaled by 2^16; floor is exact below 2^12.
   localparam int CELL_RECIP = (65536 + CELL_SIZE - 1) / CELL_SIZE;
   localparam int CELL_SHIFT = 16;
   localparam int PROD_W = COORD_W + CELL_SHIFT - 3;

   localparam logic [CHAN_W-1:0] LIGHT_GREY = 8'hDD;
   localparam logic [CHAN_W-1:0] DARK_GREY = 8'hBB;
   localparam logic [CHAN_W-1:0] FULL = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_BG_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_RED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_GREEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_BLUE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_ALPHA = 3'd4;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_BG,
      KIND_BLEND
   } kind_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rgba_type;

endpackage

[src/acoc_if.sv]
interface acoc_req_if import acoc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pix_x;
   logic [COORD_W-1:0] pix_y;
   logic [CHAN_W-1:0]  src_red;
   logic [CHAN_W-1:0]  src_green;
   logic [CHAN_W-1:0]  src_blue;
   logic [CHAN_W-1:0]  src_alpha;

   modport source (output valid, pix_x, pix_y, src_red, src_green, src_blue, src_alpha,
                   input ready);
   modport sink (input valid, pix_x, pix_y, src_red, src_green, src_blue, src_alpha,
                 output ready);
endinterface

interface acoc_rsp_if import acoc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic [CHAN_W-1:0] out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface acoc_csr_if import acoc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] idx;
   logic [CHAN_W-1:0]    wdata;

   modport source (output valid, idx, wdata, input ready);
   modport sink (input valid, idx, wdata, output ready);
endinterface

[src/acoc_cell.sv]
module acoc_cell import acoc_pkg::*; (
   input  logic [COORD_W-1:0] pix_x,
   input  logic [COORD_W-1:0] pix_y,
   output logic               light
);

   logic [PROD_W-1:0] prod_x;
   logic [PROD_W-1:0] prod_y;

   // The quotient by the cell size sits above bit CELL_SHIFT; only its parity matters.
   assign prod_x = PROD_W'(pix_x) * PROD_W'(CELL_RECIP);
   assign prod_y = PROD_W'(pix_y) * PROD_W'(CELL_RECIP);
   assign light = ~(prod_x[CELL_SHIFT] ^ prod_y[CELL_SHIFT]);

endmodule

[src/alpha_composite_over_checker_core.sv]
// A pixel taken in passes the stage 1, stage 2 and stage 3 registers in turn before
// it is offered at the output. Throughput: one pixel per cycle while the output
// accepts; under stall a stage advances when it is empty or the next one advances.
// The three stages are cell parity, channel products, and the divide by 255.
// Reset (synchronous, active high) empties the pipeline and restores the
// background registers to checkerboard mode with solid color 0,0,0 alpha 255.
`include "alpha_composite_over_checker_core_macros.svh"

module alpha_composite_over_checker_core import acoc_pkg::*; #(
   parameter int MAX_IMAGE_DIM = 4096
) (
   input logic       clock,
   input logic       reset,
   acoc_csr_if.sink  csr_ch,
   acoc_req_if.sink  req_ch,
   acoc_rsp_if.source rsp_ch
);

   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = 17'(n) + 17'd1 + 17'(n[15:8]);
      return t[15:8];
   endfunction

   logic        bg_mode_ff;
   rgba_type    bg_color_ff;

   logic        v1_ff, v2_ff, v3_ff;
   logic        adv1, adv2, adv3;

   logic [COORD_W-1:0] x_mod, y_mod;
   logic        light1_in, light1_ff;
   kind_type    kind1_in, kind1_ff;
   rgba_type    src1_ff;

   rgba_type    bg2;
   rgba_type    direct2_in, direct2_ff;
   logic [15:0] sum_r_in, sum_g_in, sum_b_in;
   logic [15:0] sum_r_ff, sum_g_ff, sum_b_ff;
   kind_type    kind2_ff;
   logic [CHAN_W-1:0] inv_a;

   rgba_type    out3_in, out3_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_mode_ff <= 1'b0;
         bg_color_ff <= '{red: '0, green: '0, blue: '0, alpha: FULL};
      end else if (csr_ch.valid) begin
         case (csr_ch.idx)
            CSR_BG_MODE:  bg_mode_ff <= csr_ch.wdata[0];
            CSR_BG_RED:   bg_color_ff.red <= csr_ch.wdata;
            CSR_BG_GREEN: bg_color_ff.green <= csr_ch.wdata;
            CSR_BG_BLUE:  bg_color_ff.blue <= csr_ch.wdata;
            CSR_BG_ALPHA: bg_color_ff.alpha <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   assign adv3 = !v3_ff || rsp_ch.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ch.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_ch.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: checkerboard cell parity and source classification.
   assign x_mod = COORD_W'(32'(req_ch.pix_x) % MAX_IMAGE_DIM);
   assign y_mod = COORD_W'(32'(req_ch.pix_y) % MAX_IMAGE_DIM);

   acoc_cell u_cell (
      .pix_x (x_mod),
      .pix_y (y_mod),
      .light (light1_in)
   );

   always_comb begin
      if (req_ch.src_alpha == FULL) begin
         kind1_in = KIND_PASS;
      end else if (req_ch.src_alpha == '0) begin
         kind1_in = KIND_BG;
      end else begin
         kind1_in = KIND_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_ch.valid) begin
         light1_ff <= light1_in;
         kind1_ff <= kind1_in;
         src1_ff <= '{red: req_ch.src_red, green: req_ch.src_green,
                      blue: req_ch.src_blue, alpha: req_ch.src_alpha};
      end
   end

   // Stage 2: background selection and the weighted channel sums.
   always_comb begin
      if (bg_mode_ff) begin
         bg2 = bg_color_ff;
      end else begin
         bg2.red = light1_ff ? LIGHT_GREY : DARK_GREY;
         bg2.green = bg2.red;
         bg2.blue = bg2.red;
         bg2.alpha = FULL;
      end
   end

   assign inv_a = FULL - src1_ff.alpha;
   assign sum_r_in = 16'(src1_ff.red) * 16'(src1_ff.alpha) + 16'(bg2.red) * 16'(inv_a);
   assign sum_g_in = 16'(src1_ff.green) * 16'(src1_ff.alpha) + 16'(bg2.green) * 16'(inv_a);
   assign sum_b_in = 16'(src1_ff.blue) * 16'(src1_ff.alpha) + 16'(bg2.blue) * 16'(inv_a);
   assign direct2_in = (kind1_ff == KIND_PASS) ? src1_ff : bg2;

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
         direct2_ff <= direct2_in;
         kind2_ff <= kind1_ff;
      end
   end

   // Stage 3: exact floor division by 255 and final selection.
   always_comb begin
      if (kind2_ff == KIND_BLEND) begin
         out3_in = '{red: div255(sum_r_ff), green: div255(sum_g_ff),
                     blue: div255(sum_b_ff), alpha: FULL};
      end else begin
         out3_in = direct2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         out3_ff <= out3_in;
      end
   end

   assign rsp_ch.valid = v3_ff;
   assign rsp_ch.out_red = out3_ff.red;
   assign rsp_ch.out_green = out3_ff.green;
   assign rsp_ch.out_blue = out3_ff.blue;
   assign rsp_ch.out_alpha = out3_ff.alpha;

   `ACOC_ASSERT_IMPLY(a_stall_full, !req_ch.ready, v1_ff && v2_ff && v3_ff)
   `ACOC_ASSERT_NEXT(a_enter_stage1, req_ch.valid && req_ch.ready, v1_ff)
   `ACOC_ASSERT_NEXT(a_blend_opaque, v2_ff && adv3 && kind2_ff == KIND_BLEND,
                     rsp_ch.valid && rsp_ch.out_alpha == FULL)
   `ACOC_ASSERT_IMPLY(a_reset_empty, $past(reset), !v1_ff && !v2_ff && !v3_ff)

endmodule
